// ===== sv/wmsq_pkg.sv =====
`timescale 1ns / 1ps

package wmsq_pkg;

    // Default waypoint table depth.
    localparam int WP_DEPTH_DEF = 8;

    // Depth of the queue between the front and the back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port geometry.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_HOLD_ALT    = 3'd0;
    localparam logic [2:0] REG_TAKEOFF_ALT = 3'd1;
    localparam logic [2:0] REG_ARRIVAL_TOL = 3'd2;
    localparam logic [2:0] REG_STREAM_TICKS = 3'd3;
    localparam logic [2:0] REG_WP_COUNT    = 3'd4;

    // Register reset values.
    localparam logic signed [23:0] HOLD_ALT_RST    = -24'sd512;
    localparam logic signed [23:0] TAKEOFF_ALT_RST = -24'sd1280;
    localparam logic [22:0]        ARRIVAL_TOL_RST = 23'd256;
    localparam logic [7:0]         STREAM_TICKS_RST = 8'd10;
    localparam logic [3:0]         WP_COUNT_RST    = 4'd5;

    // Mission phases, numbered as they are reported.
    typedef enum logic [2:0] {
        PH_STREAM    = 3'd0,
        PH_WAIT_MODE = 3'd1,
        PH_WAIT_ARM  = 3'd2,
        PH_TAKEOFF   = 3'd3,
        PH_WAYPOINTS = 3'd4,
        PH_HOME      = 3'd5,
        PH_LAND      = 3'd6,
        PH_DONE      = 3'd7
    } t_phase;

    // Requests to the vehicle.
    typedef enum logic [1:0] {
        REQ_NONE     = 2'd0,
        REQ_OFFBOARD = 2'd1,
        REQ_ARM      = 2'd2,
        REQ_LAND     = 2'd3
    } t_req;

    // Item kinds.
    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_LOAD = 1'b1
    } t_kind;

    // Input transaction payload.
    typedef struct packed {
        logic              cmd;
        logic [2:0]        slot;
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [23:0] coord_z;
        logic              position_valid;
        logic              offboard_active;
        logic              armed;
    } t_item;

    // Output transaction payload.
    typedef struct packed {
        logic              setpoint_valid;
        logic signed [23:0] setpoint_x;
        logic signed [23:0] setpoint_y;
        logic signed [23:0] setpoint_z;
        logic [1:0]        vehicle_request;
        logic [2:0]        phase;
        logic [3:0]        current_waypoint;
    } t_result;

    // Classified item as it travels through the queue.
    typedef struct packed {
        t_kind             kind;
        logic              wr_en;
        logic [2:0]        slot;
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [23:0] coord_z;
        logic              position_valid;
        logic              offboard_active;
        logic              armed;
    } t_op;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic signed [23:0] hold_alt;
        logic signed [23:0] takeoff_alt;
        logic [45:0]       tol_sq;
        logic [7:0]        stream_ticks;
        logic [3:0]        wp_count;
    } t_cfg;

endpackage

// ===== sv/wmsq_regs.sv =====
`timescale 1ns / 1ps

module wmsq_regs
    import wmsq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic signed [23:0] r_hold_alt;
    logic signed [23:0] r_takeoff_alt;
    logic [22:0]        r_tol;
    logic [45:0]        r_tol_sq;
    logic [7:0]         r_stream_ticks;
    logic [3:0]         r_wp_count;
    logic               wr_en;
    logic [2:0]         reg_idx;
    logic [45:0]        tol_sq_c;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // The squared tolerance is kept in a register so the arrival test
    // needs no multiplier of its own.
    assign tol_sq_c = {23'd0, r_tol} * {23'd0, r_tol};

    // Register writes complete in the access phase of a write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_alt     <= HOLD_ALT_RST;
            r_takeoff_alt  <= TAKEOFF_ALT_RST;
            r_tol          <= ARRIVAL_TOL_RST;
            r_tol_sq       <= {23'd0, ARRIVAL_TOL_RST} * {23'd0, ARRIVAL_TOL_RST};
            r_stream_ticks <= STREAM_TICKS_RST;
            r_wp_count     <= WP_COUNT_RST;
        end else begin
            r_tol_sq <= tol_sq_c;
            if (wr_en) begin
                case (reg_idx)
                    REG_HOLD_ALT:     r_hold_alt     <= pwdata[23:0];
                    REG_TAKEOFF_ALT:  r_takeoff_alt  <= pwdata[23:0];
                    REG_ARRIVAL_TOL:  r_tol          <= pwdata[22:0];
                    REG_STREAM_TICKS: r_stream_ticks <= pwdata[7:0];
                    REG_WP_COUNT:     r_wp_count     <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    // Read data is returned from the current register contents.
    always_comb begin
        case (reg_idx)
            REG_HOLD_ALT:     prdata = {{8{r_hold_alt[23]}}, r_hold_alt};
            REG_TAKEOFF_ALT:  prdata = {{8{r_takeoff_alt[23]}}, r_takeoff_alt};
            REG_ARRIVAL_TOL:  prdata = {9'd0, r_tol};
            REG_STREAM_TICKS: prdata = {24'd0, r_stream_ticks};
            REG_WP_COUNT:     prdata = {28'd0, r_wp_count};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.hold_alt     = r_hold_alt;
    assign o_cfg.takeoff_alt  = r_takeoff_alt;
    assign o_cfg.tol_sq       = r_tol_sq;
    assign o_cfg.stream_ticks = r_stream_ticks;
    assign o_cfg.wp_count     = r_wp_count;

endmodule

// ===== sv/wmsq_front.sv =====
`timescale 1ns / 1ps

module wmsq_front
    import wmsq_pkg::*;
#(
    parameter int WAYPOINT_DEPTH = WP_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_item i_in_item,
    input  logic  i_q_full,
    output logic  o_push,
    output t_op   o_op
);

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic accept;

    assign o_push     = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    // Classify the incoming item as a tick or a load; only in-range loads write.
    always_comb begin
        n_op.kind            = i_in_item.cmd ? KIND_LOAD : KIND_TICK;
        n_op.wr_en           = i_in_item.cmd && (32'(i_in_item.slot) < WAYPOINT_DEPTH);
        n_op.slot            = i_in_item.slot;
        n_op.coord_x         = i_in_item.coord_x;
        n_op.coord_y         = i_in_item.coord_y;
        n_op.coord_z         = i_in_item.coord_z;
        n_op.position_valid  = i_in_item.position_valid;
        n_op.offboard_active = i_in_item.offboard_active;
        n_op.armed           = i_in_item.armed;
    end

    // Input stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

    assign o_op = r_op;

endmodule

// ===== sv/wmsq_fifo.sv =====
`timescale 1ns / 1ps

module wmsq_fifo
    import wmsq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_op            r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    // Pointers wrap naturally since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ===== sv/wmsq_back.sv =====
`timescale 1ns / 1ps

module wmsq_back
    import wmsq_pkg::*;
#(
    parameter int WAYPOINT_DEPTH = WP_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_op     i_q_op,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out_result
);

    localparam int AW  = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
    localparam int PXW = (AW > 4) ? AW : 4;
    localparam int SXW = (AW > 3) ? AW : 3;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } t_wp;

    // Squared distance along one axis.
    function automatic logic [49:0] sq_diff(input logic signed [23:0] a,
                                            input logic signed [23:0] b);
        logic signed [24:0] d;
        logic [24:0]        m;
        d = 25'(a) - 25'(b);
        m = d[24] ? 25'(-d) : 25'(d);
        return {25'd0, m} * {25'd0, m};
    endfunction

    t_wp     r_mem [WAYPOINT_DEPTH];
    t_wp     r_rd;
    t_phase  r_phase;
    t_phase  n_phase;
    logic [7:0] r_cnt;
    logic [7:0] n_cnt;
    logic [3:0] r_ptr;
    logic [3:0] n_ptr;
    logic [3:0] ptr_next;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    t_req       req;

    logic       is_load;
    logic       tick_go;
    logic       wr;
    logic [SXW-1:0] slot_ext;
    logic [AW-1:0]  waddr;
    logic [PXW-1:0] ptr_ext;
    logic [AW-1:0]  raddr;
    t_wp            wdata;

    logic [3:0]  count_c;
    logic        ptr_done;
    logic [7:0]  cnt_inc;
    logic        cnt_hit;
    logic signed [23:0] tgt_x;
    logic signed [23:0] tgt_y;
    logic signed [23:0] tgt_z;
    logic [51:0] dist_sq;
    logic        arrived;

    // Loads never need the output register; ticks wait for it to free up.
    assign is_load = (i_q_op.kind == KIND_LOAD);
    assign o_pop   = i_q_valid && (is_load || !r_out_valid || !i_out_stall);
    assign tick_go = o_pop && !is_load;
    assign wr      = o_pop && is_load && i_q_op.wr_en;

    // Table addressing: write at the slot, read at the pointer's next value.
    assign slot_ext = SXW'(i_q_op.slot);
    assign waddr    = slot_ext[AW-1:0];
    assign ptr_next = tick_go ? n_ptr : r_ptr;
    assign ptr_ext  = PXW'(ptr_next);
    assign raddr    = ptr_ext[AW-1:0];
    assign wdata    = '{x: i_q_op.coord_x, y: i_q_op.coord_y, z: i_q_op.coord_z};

    // Waypoint table with a registered read port and write bypass.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[waddr] <= wdata;
        end
        if (wr && (waddr == raddr)) begin
            r_rd <= wdata;
        end else begin
            r_rd <= r_mem[raddr];
        end
    end

    // Mission bookkeeping.
    assign count_c  = (32'(i_cfg.wp_count) > WAYPOINT_DEPTH) ?
                      4'(WAYPOINT_DEPTH) : i_cfg.wp_count;
    assign ptr_done = (r_ptr >= count_c);
    assign cnt_inc  = (r_cnt == 8'hFF) ? r_cnt : r_cnt + 8'd1;
    assign cnt_hit  = (cnt_inc >= i_cfg.stream_ticks);

    // Arrival test against the waypoint or against the takeoff point.
    assign tgt_x   = (r_phase == PH_WAYPOINTS) ? r_rd.x : '0;
    assign tgt_y   = (r_phase == PH_WAYPOINTS) ? r_rd.y : '0;
    assign tgt_z   = (r_phase == PH_WAYPOINTS) ? r_rd.z : i_cfg.takeoff_alt;
    assign dist_sq = 52'(sq_diff(i_q_op.coord_x, tgt_x)) +
                     52'(sq_diff(i_q_op.coord_y, tgt_y)) +
                     52'(sq_diff(i_q_op.coord_z, tgt_z));
    assign arrived = i_q_op.position_valid && (dist_sq < 52'(i_cfg.tol_sq));

    // Next phase, stream counter and waypoint pointer.
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_ptr   = r_ptr;
        case (r_phase)
            PH_STREAM: begin
                n_cnt = cnt_inc;
                if (cnt_hit) begin
                    n_phase = PH_WAIT_MODE;
                end
            end
            PH_WAIT_MODE: begin
                if (i_q_op.offboard_active) begin
                    n_phase = PH_WAIT_ARM;
                end
            end
            PH_WAIT_ARM: begin
                if (i_q_op.armed) begin
                    n_phase = PH_TAKEOFF;
                end
            end
            PH_TAKEOFF: begin
                if (arrived) begin
                    n_ptr   = '0;
                    n_phase = PH_WAYPOINTS;
                end
            end
            PH_WAYPOINTS: begin
                if (ptr_done) begin
                    n_phase = PH_HOME;
                end else if (arrived) begin
                    n_ptr = r_ptr + 4'd1;
                end
            end
            PH_HOME: begin
                if (arrived) begin
                    n_phase = PH_LAND;
                end
            end
            PH_LAND: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // Setpoint and vehicle request for this tick.
    always_comb begin
        n_out.setpoint_valid = 1'b1;
        n_out.setpoint_x     = '0;
        n_out.setpoint_y     = '0;
        n_out.setpoint_z     = '0;
        req                  = REQ_NONE;
        case (r_phase)
            PH_STREAM: begin
                n_out.setpoint_z = i_cfg.hold_alt;
                if (cnt_hit) begin
                    req = REQ_OFFBOARD;
                end
            end
            PH_WAIT_MODE: begin
                n_out.setpoint_z = i_cfg.hold_alt;
                if (i_q_op.offboard_active) begin
                    req = REQ_ARM;
                end
            end
            PH_WAIT_ARM: begin
                n_out.setpoint_z = i_cfg.hold_alt;
            end
            PH_TAKEOFF, PH_HOME: begin
                n_out.setpoint_z = i_cfg.takeoff_alt;
            end
            PH_WAYPOINTS: begin
                if (ptr_done) begin
                    n_out.setpoint_valid = 1'b0;
                end else begin
                    n_out.setpoint_x = r_rd.x;
                    n_out.setpoint_y = r_rd.y;
                    n_out.setpoint_z = r_rd.z;
                end
            end
            PH_LAND: begin
                n_out.setpoint_valid = 1'b0;
                req                  = REQ_LAND;
            end
            default: begin
                n_out.setpoint_z = i_cfg.takeoff_alt;
            end
        endcase
        n_out.vehicle_request  = req;
        n_out.phase            = n_phase;
        n_out.current_waypoint = n_ptr;
    end

    // Mission state advances once per tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STREAM;
            r_cnt   <= '0;
            r_ptr   <= '0;
        end else if (tick_go) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
        end
    end

    // Output register: holds a result until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

`ifndef SYNTHESIS
    // The mission only moves forward through its phases.
    a_phase_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_go |-> (n_phase >= r_phase))
        else $error("mission phase moved backward");

    // A land tick leaves the mission finished with a land request pending.
    a_land_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_go && (r_phase == PH_LAND)) |=>
        ((r_phase == PH_DONE) && r_out_valid && (r_out.vehicle_request == REQ_LAND)))
        else $error("land tick did not finish the mission");

    // A result without a setpoint carries zero coordinates.
    a_no_sp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.setpoint_valid) |->
        ((r_out.setpoint_x == '0) && (r_out.setpoint_y == '0) && (r_out.setpoint_z == '0)))
        else $error("setpoint coordinates not cleared");

    // A load leaves the mission state untouched.
    a_load_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_load) |=> ($stable(r_phase) && $stable(r_ptr) && $stable(r_cnt)))
        else $error("load changed mission state");
`endif

endmodule

// ===== sv/waypoint_mission_sequencer_core.sv =====
`timescale 1ns / 1ps

// Waypoint mission sequencer. Each tick transaction (measured position and
// vehicle status) yields one result transaction with a setpoint, a vehicle
// request and the phase; a load transaction writes one waypoint into the
// table and yields nothing. The block sustains one transaction per clock,
// ticks and loads freely mixed, unless the result side stalls: an input
// register classifies items, a two-entry queue decouples it from the
// sequencer, and the sequencer's waypoint table has a registered read port
// that fetches the pointer's next value with write bypass, so no item waits
// on the one before it. A result is presented by an output register; the
// arrival test (three 25-bit squarings against a stored squared tolerance)
// is combinational. The user must write configuration registers over the
// APB port only while no transaction is in flight, which the block does
// not enforce; waypoints must be loaded before the mission reaches them.
module waypoint_mission_sequencer_core
    import wmsq_pkg::*;
#(
    parameter int WAYPOINT_DEPTH = WP_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_item              i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_result            o_out_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg cfg;
    logic q_full;
    logic q_push;
    t_op  q_in_op;
    logic q_pop;
    logic q_valid;
    t_op  q_out_op;

    // Configuration registers.
    wmsq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input stage and classification.
    wmsq_front #(
        .WAYPOINT_DEPTH (WAYPOINT_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_op       (q_in_op)
    );

    // Queue between the front and the sequencer.
    wmsq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_out_op)
    );

    // Mission sequencer, waypoint table and output register.
    wmsq_back #(
        .WAYPOINT_DEPTH (WAYPOINT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_q_valid    (q_valid),
        .i_q_op       (q_out_op),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result)
    );

endmodule

// ===== dv/tb_waypoint_mission_sequencer_core.sv =====
`timescale 1ns / 1ps

module tb_waypoint_mission_sequencer_core;
    import wmsq_pkg::*;

    localparam int ROUNDS = 12;
    localparam int ITEMS_PER_ROUND = 50;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT = 2000;
    localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] COORD_MIN = 24'sh800000;

    // Tracks the mission state and configuration as the block should see them,
    // and holds the setpoints still owed by the block.
    class mission_tracker;
        logic signed [23:0] hold_alt;
        logic signed [23:0] takeoff_alt;
        logic [22:0]        tol;
        logic [7:0]         stream_ticks;
        logic [3:0]         wp_count;

        t_phase             phase;
        logic [7:0]         stream_cnt;
        logic [3:0]         wp_ptr;
        logic signed [23:0] wp_x [WP_DEPTH_DEF];
        logic signed [23:0] wp_y [WP_DEPTH_DEF];
        logic signed [23:0] wp_z [WP_DEPTH_DEF];

        t_result            pending_setpoints [$];
        logic [7:0]         phases_seen;
        int                 ticks;
        int                 loads;
        int                 arrivals;
        int                 checked;
        int                 errors;

        function new();
            hold_alt = HOLD_ALT_RST;
            takeoff_alt = TAKEOFF_ALT_RST;
            tol = ARRIVAL_TOL_RST;
            stream_ticks = STREAM_TICKS_RST;
            wp_count = WP_COUNT_RST;
            phase = PH_STREAM;
            stream_cnt = '0;
            wp_ptr = '0;
            phases_seen = 8'h01;
            ticks = 0;
            loads = 0;
            arrivals = 0;
            checked = 0;
            errors = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_HOLD_ALT:     hold_alt = value[23:0];
                REG_TAKEOFF_ALT:  takeoff_alt = value[23:0];
                REG_ARRIVAL_TOL:  tol = value[22:0];
                REG_STREAM_TICKS: stream_ticks = value[7:0];
                REG_WP_COUNT:     wp_count = value[3:0];
                default: ;
            endcase
        endfunction

        // Waypoints actually flown; counts above the table depth are clamped.
        function logic [3:0] active_count();
            return (wp_count > WP_DEPTH_DEF) ? 4'(WP_DEPTH_DEF) : wp_count;
        endfunction

        // Arrival needs a valid position strictly inside the tolerance sphere.
        function bit has_arrived(t_item it, logic signed [23:0] tx, ty, tz);
            longint dx;
            longint dy;
            longint dz;
            if (!it.position_valid) return 1'b0;
            dx = longint'($signed(it.coord_x)) - longint'(tx);
            dy = longint'($signed(it.coord_y)) - longint'(ty);
            dz = longint'($signed(it.coord_z)) - longint'(tz);
            return (dx * dx + dy * dy + dz * dz) < longint'(tol) * longint'(tol);
        endfunction

        // Steps the mission for one accepted input transaction.
        function void accept_item(t_item it);
            t_result res;
            res = '0;
            res.setpoint_valid = 1'b1;
            res.vehicle_request = REQ_NONE;
            if (it.cmd == KIND_LOAD) begin
                wp_x[it.slot] = it.coord_x;
                wp_y[it.slot] = it.coord_y;
                wp_z[it.slot] = it.coord_z;
                loads++;
                return;
            end
            ticks++;
            case (phase)
                PH_STREAM: begin
                    res.setpoint_z = hold_alt;
                    if (stream_cnt != 8'hFF) stream_cnt++;
                    if (stream_cnt >= stream_ticks) begin
                        res.vehicle_request = REQ_OFFBOARD;
                        phase = PH_WAIT_MODE;
                    end
                end
                PH_WAIT_MODE: begin
                    res.setpoint_z = hold_alt;
                    if (it.offboard_active) begin
                        res.vehicle_request = REQ_ARM;
                        phase = PH_WAIT_ARM;
                    end
                end
                PH_WAIT_ARM: begin
                    res.setpoint_z = hold_alt;
                    if (it.armed) phase = PH_TAKEOFF;
                end
                PH_TAKEOFF: begin
                    res.setpoint_z = takeoff_alt;
                    if (has_arrived(it, '0, '0, takeoff_alt)) begin
                        wp_ptr = '0;
                        phase = PH_WAYPOINTS;
                    end
                end
                PH_WAYPOINTS: begin
                    if (wp_ptr >= active_count()) begin
                        res.setpoint_valid = 1'b0;
                        phase = PH_HOME;
                    end else begin
                        res.setpoint_x = wp_x[wp_ptr[2:0]];
                        res.setpoint_y = wp_y[wp_ptr[2:0]];
                        res.setpoint_z = wp_z[wp_ptr[2:0]];
                        if (has_arrived(it, res.setpoint_x, res.setpoint_y,
                                        res.setpoint_z)) begin
                            wp_ptr++;
                            arrivals++;
                        end
                    end
                end
                PH_HOME: begin
                    res.setpoint_z = takeoff_alt;
                    if (has_arrived(it, '0, '0, takeoff_alt)) phase = PH_LAND;
                end
                PH_LAND: begin
                    res.setpoint_valid = 1'b0;
                    res.vehicle_request = REQ_LAND;
                    phase = PH_DONE;
                end
                default: begin
                    res.setpoint_z = takeoff_alt;
                end
            endcase
            res.phase = phase;
            res.current_waypoint = wp_ptr;
            phases_seen[phase] = 1'b1;
            pending_setpoints.push_back(res);
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= 10) $display("ERROR: %s", msg);
        endfunction

        function void compare_field(string name, logic [23:0] want, logic [23:0] got);
            if (want !== got)
                report_error($sformatf("result %0d %s: expected %h, actual %h",
                                       checked, name, want, got));
        endfunction

        // Compares one accepted result transaction with the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            if (pending_setpoints.size() == 0) begin
                report_error($sformatf("result with no tick outstanding: %h", got));
                return;
            end
            want = pending_setpoints.pop_front();
            checked++;
            compare_field("setpoint_valid", 24'(want.setpoint_valid),
                          24'(got.setpoint_valid));
            compare_field("setpoint_x", want.setpoint_x, got.setpoint_x);
            compare_field("setpoint_y", want.setpoint_y, got.setpoint_y);
            compare_field("setpoint_z", want.setpoint_z, got.setpoint_z);
            compare_field("vehicle_request", 24'(want.vehicle_request),
                          24'(got.vehicle_request));
            compare_field("phase", 24'(want.phase), 24'(got.phase));
            compare_field("current_waypoint", 24'(want.current_waypoint),
                          24'(got.current_waypoint));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_item              i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_result            o_out_result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mission_tracker tracker;
    int gap_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    waypoint_mission_sequencer_core dut (.*);

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Result side: check accepted results and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_result(o_out_result);
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog on cycles in which nothing moves on any port.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic signed [23:0] clamp_coord(longint v);
        if (v > longint'(COORD_MAX)) return COORD_MAX;
        if (v < longint'(COORD_MIN)) return COORD_MIN;
        return 24'(v);
    endfunction

    function automatic int offset_within(int span);
        int off;
        off = $urandom_range(0, span);
        return ($urandom_range(0, 1) != 0) ? -off : off;
    endfunction

    // Builds the next input item; ticks are steered toward whatever the
    // mission is waiting for, so that it makes progress through its phases.
    function automatic t_item next_item();
        t_item              it;
        logic signed [23:0] tx;
        logic signed [23:0] ty;
        logic signed [23:0] tz;
        bit                 has_target;
        int                 span;
        it.cmd = KIND_TICK;
        it.slot = 3'($urandom);
        it.coord_x = 24'($urandom);
        it.coord_y = 24'($urandom);
        it.coord_z = 24'($urandom);
        it.position_valid = 1'($urandom);
        it.offboard_active = 1'($urandom);
        it.armed = 1'($urandom);
        if ($urandom_range(0, 99) < 12) begin
            it.cmd = KIND_LOAD;
            return it;
        end
        has_target = 1'b0;
        tx = '0;
        ty = '0;
        tz = tracker.takeoff_alt;
        case (tracker.phase)
            PH_WAIT_MODE: it.offboard_active = ($urandom_range(0, 11) == 0);
            PH_WAIT_ARM:  it.armed = ($urandom_range(0, 11) == 0);
            PH_TAKEOFF, PH_HOME: has_target = 1'b1;
            PH_WAYPOINTS: begin
                if (tracker.wp_ptr < tracker.active_count()) begin
                    has_target = 1'b1;
                    tx = tracker.wp_x[tracker.wp_ptr[2:0]];
                    ty = tracker.wp_y[tracker.wp_ptr[2:0]];
                    tz = tracker.wp_z[tracker.wp_ptr[2:0]];
                end
            end
            default: ;
        endcase
        if (has_target && $urandom_range(0, 7) == 0) begin
            it.position_valid = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 3) == 0) begin
                // Exactly one tolerance away: the strict compare must reject it.
                it.coord_x = clamp_coord(longint'(tx) + longint'(tracker.tol));
                it.coord_y = ty;
                it.coord_z = tz;
            end else begin
                span = int'(tracker.tol) / 2;
                it.coord_x = clamp_coord(longint'(tx) + offset_within(span));
                it.coord_y = clamp_coord(longint'(ty) + offset_within(span));
                it.coord_z = clamp_coord(longint'(tz) + offset_within(span));
            end
        end
        return it;
    endfunction

    // Offers one input transaction and waits until the block takes it.
    task automatic present(input t_item it);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.accept_item(it);
    endtask

    task automatic drive_items(input int count);
        int left;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 99) < gap_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end else begin
                present(next_item());
                left--;
            end
        end
        i_in_valid <= 1'b0;
    endtask

    // One APB write: setup cycle, then access until pready. The bus is
    // released by the caller so back-to-back writes stay glitch free.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_register(idx, value);
    endtask

    // Waits until the block is idle, then writes every register for a round.
    task automatic configure(input int round_no);
        logic [31:0] hold_v;
        logic [31:0] takeoff_v;
        logic [31:0] tol_v;
        logic [31:0] stream_v;
        logic [31:0] count_v;
        while (tracker.pending_setpoints.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        case (round_no % 3)
            0:       hold_v = 32'(COORD_MIN);
            1:       hold_v = 32'(COORD_MAX);
            default: hold_v = $urandom_range(0, 24'hFFFFFF);
        endcase
        if (round_no == 0) takeoff_v = 32'(COORD_MAX);
        else if (round_no == 1) takeoff_v = 32'(COORD_MIN);
        else if (round_no % 3 == 2) takeoff_v = 32'(TAKEOFF_ALT_RST);
        else takeoff_v = $urandom_range(0, 24'hFFFFFF);

        if (round_no <= 1 || round_no == 7) tol_v = 0;
        else if (round_no == 2) tol_v = 32'(ARRIVAL_TOL_RST);
        else if (round_no % 4 == 3) tol_v = 32'h7FFFFF;
        else tol_v = $urandom_range(1, 4096);

        if (round_no <= 1) stream_v = 255;
        else if (round_no == 2) stream_v = 1;
        else stream_v = $urandom_range(1, 255);

        // Dropping the count below the pointer mid-flight sends the vehicle home.
        if (round_no == 0) count_v = 0;
        else if (round_no == 1) count_v = 15;
        else if (round_no == 2) count_v = 8;
        else if (tracker.phase == PH_WAYPOINTS && tracker.wp_ptr != 0
                 && $urandom_range(0, 1) != 0)
            count_v = $urandom_range(0, tracker.wp_ptr - 1);
        else count_v = $urandom_range(3, 15);

        write_reg(REG_HOLD_ALT, hold_v);
        write_reg(REG_TAKEOFF_ALT, takeoff_v);
        write_reg(REG_ARRIVAL_TOL, tol_v);
        write_reg(REG_STREAM_TICKS, stream_v);
        write_reg(REG_WP_COUNT, count_v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        t_item it;
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(0);

        // Directed part: fill every table slot with corner coordinates, then
        // ticks with extreme positions and every flag combination.
        for (int s = 0; s < WP_DEPTH_DEF; s++) begin
            it = '0;
            it.cmd = KIND_LOAD;
            it.slot = 3'(s);
            it.coord_x = s[0] ? COORD_MAX : COORD_MIN;
            it.coord_y = s[1] ? COORD_MIN : COORD_MAX;
            it.coord_z = s[2] ? COORD_MAX : COORD_MIN;
            it.position_valid = s[0];
            it.offboard_active = s[1];
            it.armed = s[2];
            present(it);
        end
        for (int k = 0; k < 8; k++) begin
            it = '0;
            it.cmd = KIND_TICK;
            it.slot = 3'(7 - k);
            it.coord_x = (k % 3 == 0) ? COORD_MIN : (k % 3 == 1) ? COORD_MAX : '0;
            it.coord_y = (k % 3 == 1) ? COORD_MIN : (k % 3 == 2) ? COORD_MAX : '0;
            it.coord_z = (k % 3 == 2) ? COORD_MIN : (k % 3 == 0) ? COORD_MAX : '0;
            it.position_valid = k[0];
            it.offboard_active = k[1];
            it.armed = k[2];
            present(it);
        end
        i_in_valid <= 1'b0;

        // Random rounds, each with its own settings and idling pattern.
        for (int r = 1; r <= ROUNDS; r++) begin
            configure(r);
            case (r % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 53; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 13; stall_pct = 13; end
            endcase
            drive_items(ITEMS_PER_ROUND);
        end

        while (tracker.pending_setpoints.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d ticks and %0d waypoint loads over %0d register settings;",
                 tracker.ticks, tracker.loads, ROUNDS + 1);
        $display("phases reached (bit per phase) %b, %0d waypoint arrivals, %0d results checked",
                 tracker.phases_seen, tracker.arrivals, tracker.checked);
        if (tracker.errors == 0 && tracker.pending_setpoints.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d errors, %0d results outstanding", tracker.errors,
                     tracker.pending_setpoints.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== waypoint_mission_sequencer_core.f =====
sv/wmsq_pkg.sv
sv/wmsq_regs.sv
sv/wmsq_front.sv
sv/wmsq_fifo.sv
sv/wmsq_back.sv
sv/waypoint_mission_sequencer_core.sv
dv/tb_waypoint_mission_sequencer_core.sv
